// ----- hdl/tcl_pkg.sv -----
// Shared types, constants and character helpers for the token class lexer.
package tcl_pkg;

	// Pending token length saturates here; reported length is further capped at 255.
	localparam int LENGTH_LIMIT = 255;
	localparam int LEN_W        = $clog2(LENGTH_LIMIT + 1);
	localparam int LEN_OUT_MAX  = 255;

	// Front-to-back queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Keyword and bool word tables (string literals are right-aligned)
	localparam int NUM_TYPE_WORDS = 5;
	localparam int NUM_BOOL_WORDS = 4;
	localparam int WORD_BYTES     = 6;
	localparam logic [8*WORD_BYTES-1:0] TYPE_WORD [NUM_TYPE_WORDS] =
		'{"int", "float", "bool", "char", "string"};
	localparam logic [2:0] TYPE_LEN [NUM_TYPE_WORDS] = '{3'd3, 3'd5, 3'd4, 3'd4, 3'd6};
	localparam logic [8*WORD_BYTES-1:0] BOOL_WORD [NUM_BOOL_WORDS] =
		'{"0", "1", "true", "false"};
	localparam logic [2:0] BOOL_LEN [NUM_BOOL_WORDS] = '{3'd1, 3'd1, 3'd4, 3'd5};

	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_SEMI    = 8'h3B;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_SQUOTE  = 8'h27;
	localparam logic [7:0] CH_DQUOTE  = 8'h22;
	localparam logic [7:0] CH_UNDER   = 8'h5F;
	localparam logic [7:0] CH_DOLLAR  = 8'h24;

	typedef enum logic [3:0] {
		CLS_TYPE   = 4'd0,
		CLS_INT    = 4'd1,
		CLS_FLOAT  = 4'd2,
		CLS_BOOL   = 4'd3,
		CLS_CHAR   = 4'd4,
		CLS_STRING = 4'd5,
		CLS_IDENT  = 4'd6,
		CLS_ERROR  = 4'd7,
		CLS_SEP    = 4'd8
	} cls_t;

	typedef enum logic [4:0] {
		INT_START  = 5'b00001,
		INT_SIGN   = 5'b00010,
		INT_ZERO   = 5'b00100,
		INT_DIGITS = 5'b01000,
		INT_DEAD   = 5'b10000
	} int_st_t;

	typedef enum logic [5:0] {
		FLT_START = 6'b000001,
		FLT_SIGN  = 6'b000010,
		FLT_INT   = 6'b000100,
		FLT_DOT   = 6'b001000,
		FLT_FRAC  = 6'b010000,
		FLT_DEAD  = 6'b100000
	} flt_st_t;

	typedef enum logic [4:0] {
		CHR_START  = 5'b00001,
		CHR_OPEN   = 5'b00010,
		CHR_BODY   = 5'b00100,
		CHR_CLOSED = 5'b01000,
		CHR_DEAD   = 5'b10000
	} chr_st_t;

	typedef enum logic [3:0] {
		STR_START = 4'b0001,
		STR_OPEN  = 4'b0010,
		STR_QUOTE = 4'b0100,
		STR_DEAD  = 4'b1000
	} str_st_t;

	typedef enum logic [3:0] {
		ID_START  = 4'b0001,
		ID_LETTER = 4'b0010,
		ID_OTHER  = 4'b0100,
		ID_DEAD   = 4'b1000
	} id_st_t;

	// Everything the automata know about the pending token
	typedef struct packed {
		logic [NUM_TYPE_WORDS-1:0] kw_mask;
		logic [NUM_BOOL_WORDS-1:0] bl_mask;
		logic [2:0]                pos;
		int_st_t                   int_st;
		flt_st_t                   flt_st;
		chr_st_t                   chr_st;
		str_st_t                   str_st;
		id_st_t                    id_st;
	} dfa_state_t;

	// One queue entry: results caused by one input transaction
	typedef struct packed {
		logic       has_tok;
		cls_t       tok_class;
		logic [7:0] tok_len;
		logic       has_sep;
	} q_entry_t;

	localparam dfa_state_t DFA_CLEAR = '{
		kw_mask: '1,
		bl_mask: '1,
		pos:     3'd0,
		int_st:  INT_START,
		flt_st:  FLT_START,
		chr_st:  CHR_START,
		str_st:  STR_START,
		id_st:   ID_START
	};

	function automatic logic is_digit(logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_letter(logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	endfunction

	function automatic logic [7:0] cap_len(logic [LEN_W-1:0] n);
		if (32'(n) > 32'(LEN_OUT_MAX))
			return 8'(LEN_OUT_MAX);
		return 8'(n);
	endfunction

endpackage

// ----- hdl/tcl_front.sv -----
// Front end: accepts bytes, runs the token automata and queues the results of each transaction.
module tcl_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  logic [7:0]          char_byte,
	input  logic                end_of_input,
	input  logic                q_full,
	output logic                q_push,
	output tcl_pkg::q_entry_t   q_wdata
);

	tcl_pkg::dfa_state_t         st_q;
	tcl_pkg::dfa_state_t         st_nx;
	tcl_pkg::dfa_state_t         st_sel;
	logic [tcl_pkg::LEN_W-1:0]   cnt_q;
	logic [tcl_pkg::LEN_W-1:0]   cnt_nx;
	logic [tcl_pkg::LEN_W-1:0]   cnt_sel;
	logic                        accept;
	logic                        delim;
	logic                        flush;
	logic                        kw_acc;
	logic                        bl_acc;
	tcl_pkg::cls_t               cls;

	assign byte_stall = q_full;
	assign accept     = byte_valid && !q_full;
	assign delim      = (char_byte == tcl_pkg::CH_SPACE) || (char_byte == tcl_pkg::CH_NEWLINE) ||
	                    (char_byte == tcl_pkg::CH_SEMI);

	// Advance every automaton by one byte
	always_comb begin
		int unsigned p;
		st_nx = st_q;
		p     = 32'(st_q.pos);
		for (int k = 0; k < tcl_pkg::NUM_TYPE_WORDS; k++) begin
			st_nx.kw_mask[k] = 1'b0;
			if (st_q.kw_mask[k] && (p < 32'(tcl_pkg::TYPE_LEN[k])))
				st_nx.kw_mask[k] = (tcl_pkg::TYPE_WORD[k][8*(32'(tcl_pkg::TYPE_LEN[k])-1-p) +: 8]
				                   == char_byte);
		end
		for (int k = 0; k < tcl_pkg::NUM_BOOL_WORDS; k++) begin
			st_nx.bl_mask[k] = 1'b0;
			if (st_q.bl_mask[k] && (p < 32'(tcl_pkg::BOOL_LEN[k])))
				st_nx.bl_mask[k] = (tcl_pkg::BOOL_WORD[k][8*(32'(tcl_pkg::BOOL_LEN[k])-1-p) +: 8]
				                   == char_byte);
		end
		st_nx.pos = (st_q.pos == 3'd7) ? 3'd7 : st_q.pos + 3'd1;

		case (st_q.int_st)
			tcl_pkg::INT_START: begin
				if (char_byte == tcl_pkg::CH_PLUS || char_byte == tcl_pkg::CH_MINUS)
					st_nx.int_st = tcl_pkg::INT_SIGN;
				else if (char_byte == tcl_pkg::CH_ZERO)
					st_nx.int_st = tcl_pkg::INT_ZERO;
				else if (tcl_pkg::is_digit(char_byte))
					st_nx.int_st = tcl_pkg::INT_DIGITS;
				else
					st_nx.int_st = tcl_pkg::INT_DEAD;
			end
			tcl_pkg::INT_SIGN: begin
				st_nx.int_st = (tcl_pkg::is_digit(char_byte) && char_byte != tcl_pkg::CH_ZERO) ?
				               tcl_pkg::INT_DIGITS : tcl_pkg::INT_DEAD;
			end
			tcl_pkg::INT_DIGITS: begin
				st_nx.int_st = tcl_pkg::is_digit(char_byte) ? tcl_pkg::INT_DIGITS :
				               tcl_pkg::INT_DEAD;
			end
			default: st_nx.int_st = tcl_pkg::INT_DEAD;
		endcase

		case (st_q.flt_st)
			tcl_pkg::FLT_START: begin
				if (char_byte == tcl_pkg::CH_PLUS || char_byte == tcl_pkg::CH_MINUS)
					st_nx.flt_st = tcl_pkg::FLT_SIGN;
				else if (tcl_pkg::is_digit(char_byte))
					st_nx.flt_st = tcl_pkg::FLT_INT;
				else
					st_nx.flt_st = tcl_pkg::FLT_DEAD;
			end
			tcl_pkg::FLT_SIGN: begin
				st_nx.flt_st = tcl_pkg::is_digit(char_byte) ? tcl_pkg::FLT_INT :
				               tcl_pkg::FLT_DEAD;
			end
			tcl_pkg::FLT_INT: begin
				if (char_byte == tcl_pkg::CH_DOT)
					st_nx.flt_st = tcl_pkg::FLT_DOT;
				else if (tcl_pkg::is_digit(char_byte))
					st_nx.flt_st = tcl_pkg::FLT_INT;
				else
					st_nx.flt_st = tcl_pkg::FLT_DEAD;
			end
			tcl_pkg::FLT_DOT, tcl_pkg::FLT_FRAC: begin
				st_nx.flt_st = tcl_pkg::is_digit(char_byte) ? tcl_pkg::FLT_FRAC :
				               tcl_pkg::FLT_DEAD;
			end
			default: st_nx.flt_st = tcl_pkg::FLT_DEAD;
		endcase

		case (st_q.chr_st)
			tcl_pkg::CHR_START: begin
				st_nx.chr_st = (char_byte == tcl_pkg::CH_SQUOTE) ? tcl_pkg::CHR_OPEN :
				               tcl_pkg::CHR_DEAD;
			end
			tcl_pkg::CHR_OPEN: begin
				st_nx.chr_st = (char_byte != tcl_pkg::CH_CR) ? tcl_pkg::CHR_BODY :
				               tcl_pkg::CHR_DEAD;
			end
			tcl_pkg::CHR_BODY: begin
				st_nx.chr_st = (char_byte == tcl_pkg::CH_SQUOTE) ? tcl_pkg::CHR_CLOSED :
				               tcl_pkg::CHR_DEAD;
			end
			default: st_nx.chr_st = tcl_pkg::CHR_DEAD;
		endcase

		case (st_q.str_st)
			tcl_pkg::STR_START: begin
				st_nx.str_st = (char_byte == tcl_pkg::CH_DQUOTE) ? tcl_pkg::STR_OPEN :
				               tcl_pkg::STR_DEAD;
			end
			tcl_pkg::STR_OPEN, tcl_pkg::STR_QUOTE: begin
				if (char_byte == tcl_pkg::CH_CR)
					st_nx.str_st = tcl_pkg::STR_DEAD;
				else if (char_byte == tcl_pkg::CH_DQUOTE)
					st_nx.str_st = tcl_pkg::STR_QUOTE;
				else
					st_nx.str_st = tcl_pkg::STR_OPEN;
			end
			default: st_nx.str_st = tcl_pkg::STR_DEAD;
		endcase

		case (st_q.id_st)
			tcl_pkg::ID_START: begin
				st_nx.id_st = tcl_pkg::is_letter(char_byte) ? tcl_pkg::ID_LETTER :
				              tcl_pkg::ID_DEAD;
			end
			tcl_pkg::ID_LETTER, tcl_pkg::ID_OTHER: begin
				if (tcl_pkg::is_letter(char_byte))
					st_nx.id_st = tcl_pkg::ID_LETTER;
				else if (tcl_pkg::is_digit(char_byte) || char_byte == tcl_pkg::CH_UNDER ||
				         char_byte == tcl_pkg::CH_DOLLAR)
					st_nx.id_st = tcl_pkg::ID_OTHER;
				else
					st_nx.id_st = tcl_pkg::ID_DEAD;
			end
			default: st_nx.id_st = tcl_pkg::ID_DEAD;
		endcase
	end

	assign cnt_nx = (32'(cnt_q) < 32'(tcl_pkg::LENGTH_LIMIT)) ? cnt_q + 1'b1 : cnt_q;

	// A delimiter classifies what is pending; a last byte classifies after appending
	assign st_sel  = delim ? st_q : st_nx;
	assign cnt_sel = delim ? cnt_q : cnt_nx;
	assign flush   = delim ? (cnt_q != '0) : end_of_input;

	always_comb begin
		kw_acc = 1'b0;
		bl_acc = 1'b0;
		for (int k = 0; k < tcl_pkg::NUM_TYPE_WORDS; k++)
			if (st_sel.kw_mask[k] && st_sel.pos == tcl_pkg::TYPE_LEN[k])
				kw_acc = 1'b1;
		for (int k = 0; k < tcl_pkg::NUM_BOOL_WORDS; k++)
			if (st_sel.bl_mask[k] && st_sel.pos == tcl_pkg::BOOL_LEN[k])
				bl_acc = 1'b1;
	end

	always_comb begin
		if (kw_acc)
			cls = tcl_pkg::CLS_TYPE;
		else if (st_sel.int_st == tcl_pkg::INT_ZERO || st_sel.int_st == tcl_pkg::INT_DIGITS)
			cls = tcl_pkg::CLS_INT;
		else if (st_sel.flt_st == tcl_pkg::FLT_INT || st_sel.flt_st == tcl_pkg::FLT_FRAC)
			cls = tcl_pkg::CLS_FLOAT;
		else if (bl_acc)
			cls = tcl_pkg::CLS_BOOL;
		else if (st_sel.chr_st == tcl_pkg::CHR_CLOSED)
			cls = tcl_pkg::CLS_CHAR;
		else if (st_sel.str_st == tcl_pkg::STR_QUOTE)
			cls = tcl_pkg::CLS_STRING;
		else if (st_sel.id_st == tcl_pkg::ID_LETTER)
			cls = tcl_pkg::CLS_IDENT;
		else
			cls = tcl_pkg::CLS_ERROR;
	end

	assign q_wdata.has_tok   = flush;
	assign q_wdata.tok_class = cls;
	assign q_wdata.tok_len   = tcl_pkg::cap_len(cnt_sel);
	assign q_wdata.has_sep   = (char_byte == tcl_pkg::CH_SEMI);
	assign q_push            = accept && (q_wdata.has_tok || q_wdata.has_sep);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= tcl_pkg::DFA_CLEAR;
			cnt_q <= '0;
		end else if (accept) begin
			if (delim || end_of_input) begin
				st_q  <= tcl_pkg::DFA_CLEAR;
				cnt_q <= '0;
			end else begin
				st_q  <= st_nx;
				cnt_q <= cnt_nx;
			end
		end
	end

endmodule

// ----- hdl/tcl_fifo.sv -----
// Short queue of per-transaction result records between front and back end.
module tcl_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  tcl_pkg::q_entry_t   wdata,
	output logic                full,
	input  logic                pop,
	output tcl_pkg::q_entry_t   rdata,
	output logic                empty
);

	tcl_pkg::q_entry_t            mem_q [tcl_pkg::QUEUE_DEPTH];
	logic [tcl_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [tcl_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [tcl_pkg::QCNT_W-1:0]   count_q;
	logic                         do_push;
	logic                         do_pop;

	assign full    = (count_q == tcl_pkg::QCNT_W'(tcl_pkg::QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == tcl_pkg::QPTR_W'(tcl_pkg::QUEUE_DEPTH - 1)) ? '0 :
				            wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == tcl_pkg::QPTR_W'(tcl_pkg::QUEUE_DEPTH - 1)) ? '0 :
				            rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ----- hdl/tcl_back.sv -----
// Back end: unpacks queued records into result transactions through an output register.
module tcl_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  tcl_pkg::q_entry_t   q_rdata,
	output logic                q_pop,
	output logic                res_valid,
	input  logic                res_stall,
	output logic [3:0]          token_class,
	output logic [7:0]          token_length,
	output logic                last_of_run
);

	logic           valid_q;
	logic           sep_pend_q;
	tcl_pkg::cls_t  class_q;
	logic [7:0]     len_q;
	logic           last_q;
	logic           load;

	assign load  = !valid_q || !res_stall;
	assign q_pop = load && !sep_pend_q && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			sep_pend_q <= 1'b0;
		end else if (load) begin
			if (sep_pend_q) begin
				valid_q    <= 1'b1;
				sep_pend_q <= 1'b0;
			end else if (!q_empty) begin
				valid_q    <= 1'b1;
				sep_pend_q <= q_rdata.has_tok && q_rdata.has_sep;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	// Token goes first; a trailing separator waits one transaction
	always_ff @(posedge clk) begin
		if (load) begin
			if (sep_pend_q || (!q_empty && !q_rdata.has_tok)) begin
				class_q <= tcl_pkg::CLS_SEP;
				len_q   <= 8'd1;
				last_q  <= 1'b1;
			end else if (!q_empty) begin
				class_q <= q_rdata.tok_class;
				len_q   <= q_rdata.tok_len;
				last_q  <= !q_rdata.has_sep;
			end
		end
	end

	assign res_valid    = valid_q;
	assign token_class  = class_q;
	assign token_length = len_q;
	assign last_of_run  = last_q;

endmodule

// ----- hdl/token_class_lexer.sv -----
// Top level of the token class lexer: front end, result queue and back end.
//
//  Channel | Handshake              | Payload
//  --------+------------------------+------------------------------------------
//  input   | byte_valid, byte_stall | char_byte, end_of_input
//  result  | res_valid, res_stall   | token_class, token_length, last_of_run
//
// One byte is taken every cycle while the queue is not full; the automata step once per byte in the front end.
// The output register delivers one result per cycle while res_stall is low, so a semicolon that ends a token
// occupies the back end for two results; the four-entry queue absorbs such bursts.
// The results of an accepted byte pass through the queue and then the output register.
// arst_n clears the automata, the queue and the output register at once.
// byte_stall rises only while the queue is full.
module token_class_lexer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  char_byte,
	input  logic        end_of_input,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [3:0]  token_class,
	output logic [7:0]  token_length,
	output logic        last_of_run
);

	logic               q_push;
	logic               q_pop;
	logic               q_full;
	logic               q_empty;
	tcl_pkg::q_entry_t  q_wdata;
	tcl_pkg::q_entry_t  q_rdata;

	tcl_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.char_byte    (char_byte),
		.end_of_input (end_of_input),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_wdata      (q_wdata)
	);

	tcl_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	tcl_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_rdata      (q_rdata),
		.q_pop        (q_pop),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.token_class  (token_class),
		.token_length (token_length),
		.last_of_run  (last_of_run)
	);

`ifndef SYNTHESIS
	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue written while full");

	a_pop_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue read while empty");

	a_sep_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_stall && !last_of_run) |=>
			(res_valid && token_class == tcl_pkg::CLS_SEP))
		else $error("separator did not follow a non-final token");

	a_sep_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && token_class == tcl_pkg::CLS_SEP) |-> (last_of_run && token_length == 8'd1))
		else $error("malformed separator transaction");
`endif

endmodule

// ----- test/token_class_lexer_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the token class lexer: byte stream in, classified tokens out.
module token_class_lexer_test;
	import tcl_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 120;
	localparam int DRAIN_CYCLES = 16;
	localparam int RANDOM_BYTES = 280;
	localparam int MAX_REPORTS  = 100;

	localparam string LETTERS    = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
	localparam string WORD_CHARS = "abcxyzABCXYZ0123456789_$";
	localparam string MIX_CHARS  = "+-.0123456789'\"_$aeflrstu";

	typedef struct {
		cls_t       cls;
		logic [7:0] len;
		logic       last;
	} token_result_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       byte_valid;
	logic       byte_stall;
	logic [7:0] char_byte;
	logic       end_of_input;
	logic       res_valid;
	logic       res_stall;
	logic [3:0] token_class;
	logic [7:0] token_length;
	logic       last_of_run;

	token_class_lexer uut (.*);

	// Pending-token automata
	string       type_words [5] = '{"int", "float", "bool", "char", "string"};
	string       bool_words [4] = '{"0", "1", "true", "false"};
	logic [4:0]  kw_alive;
	logic [3:0]  bl_alive;
	int unsigned word_pos;
	int unsigned pend_count;
	int_st_t     int_state;
	flt_st_t     flt_state;
	chr_st_t     chr_state;
	str_st_t     str_state;
	id_st_t      id_state;

	token_result_t token_results[$];

	int unsigned cycle_count = 0;
	int unsigned error_count = 0;
	int unsigned bytes_sent  = 0;
	int unsigned burst_left  = 0;
	int unsigned stall_pct   = 0;
	bit          sender_gaps = 1'b0;
	bit          hold_req    = 1'b0;
	int unsigned hold_left   = 0;
	int unsigned stall_run   = 0;
	bit          stall_on    = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic bit is_dec(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit is_delim(logic [7:0] c);
		return c == CH_SPACE || c == CH_NEWLINE || c == CH_SEMI;
	endfunction

	function automatic void clear_pending();
		kw_alive   = '1;
		bl_alive   = '1;
		word_pos   = 0;
		pend_count = 0;
		int_state  = INT_START;
		flt_state  = FLT_START;
		chr_state  = CHR_START;
		str_state  = STR_START;
		id_state   = ID_START;
	endfunction

	function automatic void advance_automata(logic [7:0] c);
		for (int k = 0; k < 5; k++)
			if (word_pos >= type_words[k].len() || 8'(type_words[k][word_pos]) != c)
				kw_alive[k] = 1'b0;
		for (int k = 0; k < 4; k++)
			if (word_pos >= bool_words[k].len() || 8'(bool_words[k][word_pos]) != c)
				bl_alive[k] = 1'b0;
		word_pos++;

		case (int_state)
			INT_START: begin
				if (c == CH_PLUS || c == CH_MINUS) int_state = INT_SIGN;
				else if (c == CH_ZERO) int_state = INT_ZERO;
				else int_state = is_dec(c) ? INT_DIGITS : INT_DEAD;
			end
			INT_SIGN: int_state = (is_dec(c) && c != CH_ZERO) ? INT_DIGITS : INT_DEAD;
			INT_DIGITS: int_state = is_dec(c) ? INT_DIGITS : INT_DEAD;
			default: int_state = INT_DEAD;
		endcase

		case (flt_state)
			FLT_START: begin
				if (c == CH_PLUS || c == CH_MINUS) flt_state = FLT_SIGN;
				else flt_state = is_dec(c) ? FLT_INT : FLT_DEAD;
			end
			FLT_SIGN: flt_state = is_dec(c) ? FLT_INT : FLT_DEAD;
			FLT_INT: begin
				if (c == CH_DOT) flt_state = FLT_DOT;
				else flt_state = is_dec(c) ? FLT_INT : FLT_DEAD;
			end
			FLT_DOT, FLT_FRAC: flt_state = is_dec(c) ? FLT_FRAC : FLT_DEAD;
			default: flt_state = FLT_DEAD;
		endcase

		case (chr_state)
			CHR_START: chr_state = (c == CH_SQUOTE) ? CHR_OPEN : CHR_DEAD;
			CHR_OPEN: chr_state = (c != CH_CR) ? CHR_BODY : CHR_DEAD;
			CHR_BODY: chr_state = (c == CH_SQUOTE) ? CHR_CLOSED : CHR_DEAD;
			default: chr_state = CHR_DEAD;
		endcase

		if (str_state == STR_START) str_state = (c == CH_DQUOTE) ? STR_OPEN : STR_DEAD;
		else if (str_state == STR_DEAD || c == CH_CR) str_state = STR_DEAD;
		else str_state = (c == CH_DQUOTE) ? STR_QUOTE : STR_OPEN;

		if (id_state == ID_START) id_state = is_alpha(c) ? ID_LETTER : ID_DEAD;
		else if (id_state == ID_DEAD) id_state = ID_DEAD;
		else if (is_alpha(c)) id_state = ID_LETTER;
		else if (is_dec(c) || c == CH_UNDER || c == CH_DOLLAR) id_state = ID_OTHER;
		else id_state = ID_DEAD;

		if (pend_count < LENGTH_LIMIT) pend_count++;
	endfunction

	function automatic cls_t pending_class();
		for (int k = 0; k < 5; k++)
			if (kw_alive[k] && word_pos == type_words[k].len()) return CLS_TYPE;
		if (int_state == INT_ZERO || int_state == INT_DIGITS) return CLS_INT;
		if (flt_state == FLT_INT || flt_state == FLT_FRAC) return CLS_FLOAT;
		for (int k = 0; k < 4; k++)
			if (bl_alive[k] && word_pos == bool_words[k].len()) return CLS_BOOL;
		if (chr_state == CHR_CLOSED) return CLS_CHAR;
		if (str_state == STR_QUOTE) return CLS_STRING;
		if (id_state == ID_LETTER) return CLS_IDENT;
		return CLS_ERROR;
	endfunction

	function automatic void flush_pending(ref token_result_t batch[$]);
		token_result_t r;
		if (pend_count != 0) begin
			r.cls  = pending_class();
			r.len  = (pend_count > 255) ? 8'd255 : 8'(pend_count);
			r.last = 1'b0;
			batch.insert(batch.size(), r);
			clear_pending();
		end
	endfunction

	// Work out the results one accepted byte causes and queue them
	function automatic void lex_byte(logic [7:0] c, logic eoi);
		token_result_t batch[$];
		token_result_t sep;
		if (is_delim(c)) begin
			flush_pending(batch);
			if (c == CH_SEMI) begin
				sep.cls  = CLS_SEP;
				sep.len  = 8'd1;
				sep.last = 1'b0;
				batch.insert(batch.size(), sep);
			end
		end else begin
			advance_automata(c);
			if (eoi) flush_pending(batch);
		end
		if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
		foreach (batch[i]) token_results.insert(token_results.size(), batch[i]);
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		if (error_count < MAX_REPORTS)
			$display("[cycle %0d] %s: got %0d, expected %0d", cycle_count, what, got, want);
		error_count++;
	endtask

	always @(posedge clk) begin
		token_result_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (token_results.size() == 0) begin
				report_mismatch("result with nothing expected, class", token_class, 0);
			end else begin
				want = token_results.pop_front();
				if (token_class !== want.cls)
					report_mismatch("token_class", token_class, want.cls);
				if (token_length !== want.len)
					report_mismatch("token_length", token_length, want.len);
				if (last_of_run !== want.last)
					report_mismatch("last_of_run", last_of_run, want.last);
			end
		end
	end

	// Receiver: random stall runs, or a long hold-off when asked
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else begin
			if (stall_run == 0) begin
				stall_on  = ($urandom_range(0, 99) < stall_pct);
				stall_run = $urandom_range(1, 6);
			end
			stall_run--;
			res_stall <= stall_on;
		end
	end

	// Called and returns at a falling edge; holds the payload until the transaction
	task automatic send_byte(logic [7:0] c, logic eoi);
		int unsigned gap;
		if (sender_gaps && burst_left == 0) begin
			gap = $urandom_range(0, 4);
			if (gap > 0) begin
				byte_valid   <= 1'b0;
				char_byte    <= 8'($urandom);
				end_of_input <= 1'($urandom);
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		if (burst_left > 0) burst_left--;
		byte_valid   <= 1'b1;
		char_byte    <= c;
		end_of_input <= eoi;
		do @(posedge clk); while (byte_stall);
		lex_byte(c, eoi);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(string s, bit eoi_at_end = 1'b0);
		for (int i = 0; i < s.len(); i++)
			send_byte(8'(s[i]), eoi_at_end && i == s.len() - 1);
	endtask

	function automatic logic [7:0] pick(string set);
		return 8'(set[$urandom_range(0, set.len() - 1)]);
	endfunction

	function automatic logic [7:0] body_byte();
		logic [7:0] b;
		do b = 8'($urandom); while (is_delim(b));
		return b;
	endfunction

	function automatic void add_byte(ref logic [7:0] tok[$], input logic [7:0] b);
		tok.insert(tok.size(), b);
	endfunction

	function automatic void push_sign(ref logic [7:0] tok[$]);
		case ($urandom_range(0, 2))
			1: add_byte(tok, CH_PLUS);
			2: add_byte(tok, CH_MINUS);
			default: ;
		endcase
	endfunction

	// Mostly well-formed tokens of every class, with near misses and noise mixed in
	function automatic void build_token(ref logic [7:0] tok[$]);
		string w;
		int unsigned n;
		tok.delete();
		case ($urandom_range(0, 9))
			0: begin
				w = type_words[$urandom_range(0, 4)];
				for (int i = 0; i < w.len(); i++) add_byte(tok, 8'(w[i]));
				if ($urandom_range(0, 4) == 0) begin
					if ($urandom_range(0, 1)) void'(tok.pop_back());
					else add_byte(tok, pick(LETTERS));
				end
			end
			1: begin
				push_sign(tok);
				if ($urandom_range(0, 5) == 0) begin
					add_byte(tok, CH_ZERO);
				end else begin
					add_byte(tok, pick("123456789"));
					n = $urandom_range(0, 5);
					repeat (n) add_byte(tok, pick("0123456789"));
				end
			end
			2: begin
				push_sign(tok);
				n = $urandom_range(1, 3);
				repeat (n) add_byte(tok, pick("0123456789"));
				if ($urandom_range(0, 3) != 0) begin
					add_byte(tok, CH_DOT);
					n = $urandom_range(0, 3);
					repeat (n) add_byte(tok, pick("0123456789"));
				end
			end
			3: begin
				w = bool_words[$urandom_range(0, 3)];
				for (int i = 0; i < w.len(); i++) add_byte(tok, 8'(w[i]));
			end
			4: begin
				add_byte(tok, CH_SQUOTE);
				add_byte(tok, ($urandom_range(0, 5) == 0) ? CH_CR : body_byte());
				if ($urandom_range(0, 5) == 0) add_byte(tok, body_byte());
				add_byte(tok, CH_SQUOTE);
			end
			5: begin
				add_byte(tok, CH_DQUOTE);
				n = $urandom_range(0, 6);
				repeat (n) add_byte(tok, ($urandom_range(0, 7) == 0) ? CH_CR : body_byte());
				if ($urandom_range(0, 5) != 0) add_byte(tok, CH_DQUOTE);
			end
			6: begin
				add_byte(tok, pick(LETTERS));
				if ($urandom_range(0, 3) != 0) begin
					n = $urandom_range(0, 5);
					repeat (n) add_byte(tok, pick(WORD_CHARS));
					add_byte(tok, ($urandom_range(0, 5) == 0) ? pick("09_$") : pick(LETTERS));
				end
			end
			7: begin
				n = $urandom_range(1, 6);
				repeat (n) add_byte(tok, body_byte());
			end
			8: begin
				n = $urandom_range(1, 6);
				repeat (n) add_byte(tok, pick(MIX_CHARS));
			end
			default: begin
				n = $urandom_range(20, 40);
				repeat (n) add_byte(tok, pick(LETTERS));
			end
		endcase
	endfunction

	task automatic test_keywords();
		stall_pct   = 30;
		sender_gaps = 1'b1;
		send_text("int float bool char string in intx floa strings ");
	endtask

	task automatic test_numbers();
		send_text("0 -0 +7 123 007 1.5 -3.25 1. .5 + 1 true false tru 00.0 ");
	endtask

	task automatic test_quoted();
		send_text("'a' ''' '' 'ab' \"\" \"x\"y\" \"abc \" ");
		// carriage return is the one byte a quoted body refuses
		send_byte(CH_SQUOTE, 1'b0);
		send_byte(CH_CR, 1'b0);
		send_byte(CH_SQUOTE, 1'b0);
		send_byte(CH_SPACE, 1'b0);
		send_text("\"a");
		send_byte(CH_CR, 1'b0);
		send_byte(CH_DQUOTE, 1'b0);
		send_byte(CH_NEWLINE, 1'b0);
	endtask

	task automatic test_identifiers();
		send_text("a ab a1b a_ a$z Z9 _a 9a x_y$Q ");
	endtask

	task automatic test_delimiters();
		stall_pct   = 0;
		sender_gaps = 1'b0;
		send_text(";; x; \n \n");
		send_text("q", 1'b1);
		send_byte(CH_SPACE, 1'b1);
		send_text("ab;", 1'b1);
		send_text("cd ", 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(CH_SPACE, 1'b0);
	endtask

	task automatic test_long_tokens();
		stall_pct   = 50;
		sender_gaps = 1'b1;
		repeat (256) send_byte("k", 1'b0);
		send_byte(CH_SEMI, 1'b0);
		send_byte(CH_DQUOTE, 1'b0);
		repeat (254) send_byte("a", 1'b0);
		send_byte(CH_DQUOTE, 1'b1);
	endtask

	task automatic test_backpressure();
		stall_pct   = 0;
		sender_gaps = 1'b0;
		hold_req    = 1'b1;
		// each token ended by a semicolon makes two results, so the queue fills fast
		repeat (30) begin
			send_byte("7", 1'b0);
			send_byte(CH_SEMI, 1'b0);
		end
	endtask

	task automatic test_random_stream();
		int unsigned stall_levels [4] = '{0, 20, 50, 85};
		logic [7:0] tok[$];
		int unsigned first;
		int unsigned r;
		first = bytes_sent;
		while (bytes_sent - first < RANDOM_BYTES) begin
			if ($urandom_range(0, 29) == 0) begin
				stall_pct   = stall_levels[$urandom_range(0, 3)];
				sender_gaps = 1'($urandom);
			end
			r = $urandom_range(0, 19);
			if (r == 0) begin
				send_byte(pick(" \n;"), 1'($urandom));
			end else begin
				build_token(tok);
				foreach (tok[i]) send_byte(tok[i], r == 1 && i == tok.size() - 1);
				if (r != 1) begin
					r = $urandom_range(0, 19);
					if (r < 12) send_byte(CH_SPACE, r == 0);
					else if (r < 15) send_byte(CH_NEWLINE, 1'b0);
					else send_byte(CH_SEMI, r == 19);
				end
			end
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		byte_valid   = 1'b0;
		char_byte    = 8'h00;
		end_of_input = 1'b0;
		res_stall    = 1'b0;
		clear_pending();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_keywords();
		test_numbers();
		test_quoted();
		test_identifiers();
		test_delimiters();
		test_long_tokens();
		test_backpressure();
		test_random_stream();

		byte_valid <= 1'b0;
		stall_pct = 30;
		while (token_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
